FILE: src/hsv2rgb_pkg.sv
// hsv2rgb_pkg: shared widths, constants, sector codes and the hue split helper
// for the hsv to rgb converter; no dependencies
package hsv2rgb_pkg;

    // default channel precision and fixed port widths
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int HUE_W            = 9;
    localparam int CH_W             = 8;
    localparam int PACK_W           = 24;

    // hue geometry
    localparam int HUE_STEP   = 60;
    localparam int HUE_FULL   = 360;
    localparam int STEP_W     = 6;
    localparam int SECT_W     = 4;
    localparam int NUM_SECT_T = 8;

    // register stages between request and result
    localparam int NUM_STAGES = 6;

    // sector codes; anything above the blue sector selects the magenta mix
    localparam logic [SECT_W-1:0] SECT_RED    = 4'd0;
    localparam logic [SECT_W-1:0] SECT_YELLOW = 4'd1;
    localparam logic [SECT_W-1:0] SECT_GREEN  = 4'd2;
    localparam logic [SECT_W-1:0] SECT_CYAN   = 4'd3;
    localparam logic [SECT_W-1:0] SECT_BLUE   = 4'd4;

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [STEP_W-1:0] rem;
    } hue_split_t;

    // hue / 60 and hue mod 60 by threshold compares; 360 folds to 0
    function automatic hue_split_t split_hue(input logic [HUE_W-1:0] hue);
        hue_split_t       res;
        logic [HUE_W-1:0] h;
        logic [HUE_W-1:0] base;
        int               k;
        h = (hue == HUE_W'(HUE_FULL)) ? '0 : hue;
        res.sector = '0;
        for (k = 1; k <= NUM_SECT_T; k++)
        begin
            if (h >= HUE_W'(HUE_STEP * k))
            begin
                res.sector = SECT_W'(k);
            end
        end
        base    = HUE_W'(res.sector) * HUE_W'(HUE_STEP);
        res.rem = STEP_W'(h - base);
        return res;
    endfunction

endpackage

FILE: src/hsv2rgb_ctrl.sv
// hsv2rgb_ctrl: valid bits and per-stage load enables of the pipeline
// depends on hsv2rgb_pkg
module hsv2rgb_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  hsv_valid,
    input  logic                                  rgb_stall,
    output logic [hsv2rgb_pkg::NUM_STAGES-1:0]    stage_en,
    output logic                                  rgb_valid,
    output logic                                  hsv_stall
);
    import hsv2rgb_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] valid_shift;

    // a stage may load when it is empty or its successor moves on
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !rgb_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    // valid bits follow their data one stage per load
    always_comb
    begin
        valid_shift = {valid_reg[NUM_STAGES-2:0], hsv_valid};
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_shift[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rgb_valid = valid_reg[NUM_STAGES-1];
    assign hsv_stall = !stage_en[0];

endmodule

FILE: src/hsv2rgb_div_cmax.sv
// hsv2rgb_div_cmax: floor division by 2^W - 1 via shift estimate, two folds and one correction
// depends on nothing
module hsv2rgb_div_cmax #(
    parameter int W = 8,
    parameter int N = 16
) (
    input  logic [N-1:0]   dividend,
    output logic [N-W-1:0] quotient
);
    localparam int QW = N - W;
    localparam int RW = ((QW > W) ? QW : W) + 1;
    localparam int FW = RW - W;
    localparam logic [RW-1:0] CMAX_R = RW'((64'd1 << W) - 64'd1);

    logic [QW-1:0] q1;
    logic [RW-1:0] r1;
    logic [FW-1:0] q2;
    logic [RW-1:0] r2;
    logic [FW-1:0] q3;
    logic [RW-1:0] r3;

    // x >> W never overshoots; leftover x - q*(2^W-1) is low bits plus q
    assign q1 = dividend[N-1:W];
    assign r1 = RW'(dividend[W-1:0]) + RW'(q1);

    // fold the leftover twice more so it ends below twice the divisor
    assign q2 = r1[RW-1:W];
    assign r2 = RW'(r1[W-1:0]) + RW'(q2);
    assign q3 = r2[RW-1:W];
    assign r3 = RW'(r2[W-1:0]) + RW'(q3);

    // one compare settles the last step
    assign quotient = q1 + QW'(q2) + QW'(q3) + QW'(r3 >= CMAX_R);

endmodule

FILE: src/hsv2rgb_div60.sv
// hsv2rgb_div60: two-stage floor division by 60, reciprocal multiply then correction
// depends on hsv2rgb_pkg
module hsv2rgb_div60 #(
    parameter int N = 14
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [N-1:0]                    dividend,
    output logic [N-hsv2rgb_pkg::STEP_W-1:0] quotient
);
    import hsv2rgb_pkg::*;

    localparam int QW = N - STEP_W;
    localparam int KW = N - 5;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << N) / 64'(HUE_STEP);
    localparam logic [KW-1:0] RECIP      = RECIP_FULL[KW-1:0];

    logic [N+KW-1:0] prod;
    logic [KW-1:0]   est_next;
    logic [KW-1:0]   est_reg;
    logic [N-1:0]    y_reg;
    logic [N-1:0]    base;
    logic [N-1:0]    rem;

    // estimate from floor(2^N/60), at most one short
    assign prod     = (N+KW)'(dividend) * (N+KW)'(RECIP);
    assign est_next = prod[N+KW-1:N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            est_reg <= est_next;
            y_reg   <= dividend;
        end
    end

    // remainder below 120, so one compare fixes the estimate
    assign base     = N'(est_reg) * N'(HUE_STEP);
    assign rem      = y_reg - base;
    assign quotient = QW'(est_reg) + QW'(rem >= N'(HUE_STEP));

endmodule

FILE: src/hsv_to_rgb_converter_unit.sv
// hsv_to_rgb_converter_unit: top level of the pipelined hsv to rgb converter
// depends on hsv2rgb_pkg, hsv2rgb_ctrl, hsv2rgb_div_cmax, hsv2rgb_div60
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------
//   hsv     | hsv_valid / hsv_stall | hue, saturation, brightness
//   rgb     | rgb_valid / rgb_stall | red, green, blue, packed_color
//
// one request per clock while hsv_stall is low; each result is registered in every stage below
// the six register stages are decode, difference terms, products,
// divide by full scale, reciprocal estimate for /60, and correction plus select
// reset clears only the stage valid bits; no clearing pass is needed
// a stalled result holds in the output stage while empty stages keep filling;
// hsv_stall rises only once every stage holds a request
module hsv_to_rgb_converter_unit #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              hsv_valid,
    output logic                              hsv_stall,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      saturation,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      brightness,
    output logic                              rgb_valid,
    input  logic                              rgb_stall,
    output logic [hsv2rgb_pkg::CH_W-1:0]      red,
    output logic [hsv2rgb_pkg::CH_W-1:0]      green,
    output logic [hsv2rgb_pkg::CH_W-1:0]      blue,
    output logic [hsv2rgb_pkg::PACK_W-1:0]    packed_color
);
    import hsv2rgb_pkg::*;

    localparam int W   = CHANNEL_BITS;
    localparam int WD  = W + STEP_W;
    localparam int XPW = 2 * W;
    localparam int XQW = W + WD;
    localparam logic [W-1:0]  CMAX = W'((64'd1 << W) - 64'd1);
    localparam logic [WD-1:0] FULL = WD'(64'(HUE_STEP) * ((64'd1 << W) - 64'd1));

    logic [NUM_STAGES-1:0] stage_en;

    // stage 1
    logic [W-1:0]      sat_m;
    logic [W-1:0]      val_m;
    hue_split_t        split;
    logic [W-1:0]      s1_sat_reg;
    logic [W-1:0]      s1_val_reg;
    logic [SECT_W-1:0] s1_sect_reg;
    logic [STEP_W-1:0] s1_rem_reg;
    logic              s1_zs_reg;

    // stage 2
    logic [STEP_W-1:0] rem_c;
    logic [W-1:0]      s2_dp_reg;
    logic [WD-1:0]     s2_dq_reg;
    logic [WD-1:0]     s2_dt_reg;
    logic [W-1:0]      s2_val_reg;
    logic [SECT_W-1:0] s2_sect_reg;
    logic              s2_zs_reg;

    // stage 3
    logic [XPW-1:0]    s3_xp_reg;
    logic [XQW-1:0]    s3_xq_reg;
    logic [XQW-1:0]    s3_xt_reg;
    logic [W-1:0]      s3_val_reg;
    logic [SECT_W-1:0] s3_sect_reg;
    logic              s3_zs_reg;

    // stage 4
    logic [W-1:0]      p_next;
    logic [WD-1:0]     yq_next;
    logic [WD-1:0]     yt_next;
    logic [W-1:0]      s4_p_reg;
    logic [WD-1:0]     s4_yq_reg;
    logic [WD-1:0]     s4_yt_reg;
    logic [W-1:0]      s4_val_reg;
    logic [SECT_W-1:0] s4_sect_reg;
    logic              s4_zs_reg;

    // stage 5
    logic [W-1:0]      q_val;
    logic [W-1:0]      t_val;
    logic [W-1:0]      s5_p_reg;
    logic [W-1:0]      s5_val_reg;
    logic [SECT_W-1:0] s5_sect_reg;
    logic              s5_zs_reg;

    // stage 6
    logic [W-1:0]      r_next;
    logic [W-1:0]      g_next;
    logic [W-1:0]      b_next;
    logic [W-1:0]      r_reg;
    logic [W-1:0]      g_reg;
    logic [W-1:0]      b_reg;

    hsv2rgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .rgb_stall (rgb_stall),
        .stage_en  (stage_en),
        .rgb_valid (rgb_valid),
        .hsv_stall (hsv_stall)
    );

    // decode: mask channels, split hue into sector and offset
    assign sat_m = W'(saturation);
    assign val_m = W'(brightness);
    assign split = split_hue(hue);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_sat_reg  <= sat_m;
            s1_val_reg  <= val_m;
            s1_sect_reg <= split.sector;
            s1_rem_reg  <= split.rem;
            s1_zs_reg   <= (sat_m == '0);
        end
    end

    // difference terms for p, q and t
    assign rem_c = STEP_W'(HUE_STEP) - s1_rem_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_dp_reg   <= CMAX - s1_sat_reg;
            s2_dq_reg   <= FULL - WD'(s1_sat_reg) * WD'(s1_rem_reg);
            s2_dt_reg   <= FULL - WD'(s1_sat_reg) * WD'(rem_c);
            s2_val_reg  <= s1_val_reg;
            s2_sect_reg <= s1_sect_reg;
            s2_zs_reg   <= s1_zs_reg;
        end
    end

    // scale by brightness
    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_xp_reg   <= XPW'(s2_val_reg) * XPW'(s2_dp_reg);
            s3_xq_reg   <= XQW'(s2_val_reg) * XQW'(s2_dq_reg);
            s3_xt_reg   <= XQW'(s2_val_reg) * XQW'(s2_dt_reg);
            s3_val_reg  <= s2_val_reg;
            s3_sect_reg <= s2_sect_reg;
            s3_zs_reg   <= s2_zs_reg;
        end
    end

    // divide by full channel scale
    hsv2rgb_div_cmax #(.W(W), .N(XPW)) u_div_p (
        .dividend (s3_xp_reg),
        .quotient (p_next)
    );

    hsv2rgb_div_cmax #(.W(W), .N(XQW)) u_div_q (
        .dividend (s3_xq_reg),
        .quotient (yq_next)
    );

    hsv2rgb_div_cmax #(.W(W), .N(XQW)) u_div_t (
        .dividend (s3_xt_reg),
        .quotient (yt_next)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s4_p_reg    <= p_next;
            s4_yq_reg   <= yq_next;
            s4_yt_reg   <= yt_next;
            s4_val_reg  <= s3_val_reg;
            s4_sect_reg <= s3_sect_reg;
            s4_zs_reg   <= s3_zs_reg;
        end
    end

    // divide q and t terms by the hue step; register sits inside the dividers
    hsv2rgb_div60 #(.N(WD)) u_div60_q (
        .clk      (clk),
        .en       (stage_en[4]),
        .dividend (s4_yq_reg),
        .quotient (q_val)
    );

    hsv2rgb_div60 #(.N(WD)) u_div60_t (
        .clk      (clk),
        .en       (stage_en[4]),
        .dividend (s4_yt_reg),
        .quotient (t_val)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s5_p_reg    <= s4_p_reg;
            s5_val_reg  <= s4_val_reg;
            s5_sect_reg <= s4_sect_reg;
            s5_zs_reg   <= s4_zs_reg;
        end
    end

    // six-way channel select; gray when saturation is zero
    always_comb
    begin
        r_next = s5_val_reg;
        g_next = s5_p_reg;
        b_next = q_val;
        if (s5_zs_reg)
        begin
            g_next = s5_val_reg;
            b_next = s5_val_reg;
        end
        else
        begin
            case (s5_sect_reg)
                SECT_RED:
                begin
                    r_next = s5_val_reg;
                    g_next = t_val;
                    b_next = s5_p_reg;
                end
                SECT_YELLOW:
                begin
                    r_next = q_val;
                    g_next = s5_val_reg;
                    b_next = s5_p_reg;
                end
                SECT_GREEN:
                begin
                    r_next = s5_p_reg;
                    g_next = s5_val_reg;
                    b_next = t_val;
                end
                SECT_CYAN:
                begin
                    r_next = s5_p_reg;
                    g_next = q_val;
                    b_next = s5_val_reg;
                end
                SECT_BLUE:
                begin
                    r_next = t_val;
                    g_next = s5_p_reg;
                    b_next = s5_val_reg;
                end
                default:
                begin
                    r_next = s5_val_reg;
                    g_next = s5_p_reg;
                    b_next = q_val;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign red          = CH_W'(r_reg);
    assign green        = CH_W'(g_reg);
    assign blue         = CH_W'(b_reg);
    assign packed_color = PACK_W'({r_reg, g_reg, b_reg});

endmodule

FILE: src/hsv2rgb_checker.sv
// hsv2rgb_checker: port-level checks on pipeline latency, drain and back-pressure
// depends on hsv2rgb_pkg; bound to hsv_to_rgb_converter_unit at the end of this file
module hsv2rgb_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              hsv_valid,
    input  logic                              hsv_stall,
    input  logic                              rgb_valid,
    input  logic                              rgb_stall,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      red,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      green,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      blue,
    input  logic [hsv2rgb_pkg::PACK_W-1:0]    packed_color
);
    import hsv2rgb_pkg::*;

    logic acc;
    logic idle_go;

    assign acc     = hsv_valid && !hsv_stall;
    assign idle_go = !acc && !rgb_stall;

    // a request that meets no output stall over the pipeline depth must have its result out
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
        |=> rgb_valid)
        else $error("request did not reach the output within the pipeline depth");

    // consecutive free cycles without a request drain every stage, so no result may appear
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        idle_go ##1 idle_go ##1 idle_go ##1 idle_go ##1 idle_go ##1 idle_go
        |=> !rgb_valid)
        else $error("result appeared with no request behind it");

    // back-pressure reaches the input only through a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_stall |-> rgb_valid && rgb_stall)
        else $error("input stalled while the output was free");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid && $stable(packed_color)
            && $stable(red) && $stable(green) && $stable(blue))
        else $error("stalled result changed or vanished");

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_hsv2rgb_checker (.*);

FILE: test/tb.sv
// tb: self-checking testbench for hsv_to_rgb_converter_unit, built on its own
// integer hsv to rgb predictor; depends on hsv2rgb_pkg and the converter rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsv2rgb_pkg::*;

    // channel scale and hue full scale at the default precision
    localparam int unsigned CMAX       = (1 << CHANNEL_BITS_DEF) - 1;
    localparam int unsigned FULL_SCALE = HUE_STEP * CMAX;
    localparam int          IDLE_PCT   = 25;
    localparam int          STALL_LIMIT = 2000;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [PACK_W-1:0] packed_color;
    } rgb_color_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              hsv_valid = 1'b0;
    logic              hsv_stall;
    logic [HUE_W-1:0]  hue = '0;
    logic [CH_W-1:0]   saturation = '0;
    logic [CH_W-1:0]   brightness = '0;
    logic              rgb_valid;
    logic              rgb_stall = 1'b0;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [PACK_W-1:0] packed_color;

    rgb_color_t pending_colors[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    bit         no_gaps = 1'b0;

    hsv_to_rgb_converter_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .hsv_valid    (hsv_valid),
        .hsv_stall    (hsv_stall),
        .hue          (hue),
        .saturation   (saturation),
        .brightness   (brightness),
        .rgb_valid    (rgb_valid),
        .rgb_stall    (rgb_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .packed_color (packed_color)
    );

    // 20 ns clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // integer hsv to rgb conversion, truncating every channel
    function automatic rgb_color_t hsv_to_rgb(input logic [HUE_W-1:0] h_in,
                                              input logic [CH_W-1:0] s_in,
                                              input logic [CH_W-1:0] v_in);
        rgb_color_t  res;
        int unsigned h, s, v, sect, rem, p, q, t, r, g, b;
        h = h_in;
        s = s_in;
        v = v_in;
        if (s == 0)
        begin
            r = v;
            g = v;
            b = v;
        end
        else
        begin
            if (h == HUE_FULL)
                h = 0;
            sect = h / HUE_STEP;
            rem  = h % HUE_STEP;
            p = (v * (CMAX - s)) / CMAX;
            q = (v * (FULL_SCALE - s * rem)) / FULL_SCALE;
            t = (v * (FULL_SCALE - s * (HUE_STEP - rem))) / FULL_SCALE;
            case (SECT_W'(sect))
                SECT_RED:    begin r = v; g = t; b = p; end
                SECT_YELLOW: begin r = q; g = v; b = p; end
                SECT_GREEN:  begin r = p; g = v; b = t; end
                SECT_CYAN:   begin r = p; g = q; b = v; end
                SECT_BLUE:   begin r = t; g = p; b = v; end
                default:     begin r = v; g = p; b = q; end
            endcase
        end
        res.red          = r[CH_W-1:0];
        res.green        = g[CH_W-1:0];
        res.blue         = b[CH_W-1:0];
        res.packed_color = {r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0]};
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    // send one request, with random idle cycles ahead of it
    task automatic send_hsv(input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s,
                            input logic [CH_W-1:0] v);
        if (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            hsv_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge clk);
        end
        hsv_valid  <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        forever
        begin
            @(posedge clk);
            if (!hsv_stall)
                break;
        end
        pending_colors.push_back(hsv_to_rgb(h, s, v));
    endtask

    // random channel byte weighted toward the ends of the range
    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return CH_W'($urandom_range(3));
            default: return CH_W'($urandom_range(CMAX));
        endcase
    endfunction

    // random hue: mostly in range, some 360 and some past it
    function automatic logic [HUE_W-1:0] pick_hue();
        case ($urandom_range(11))
            0:       return HUE_W'(HUE_FULL);
            1:       return HUE_W'($urandom_range((1 << HUE_W) - 1, HUE_FULL + 1));
            default: return HUE_W'($urandom_range(HUE_FULL - 1));
        endcase
    endfunction

    task automatic send_random_colors(input int n);
        for (int i = 0; i < n; i++)
            send_hsv(pick_hue(), pick_channel(), pick_channel());
    endtask

    // sector edges, hue fold and overflow, zero saturation and value
    task automatic test_corner_colors();
        int edge_hues[19] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300,
                              359, 360, 361, 419, 420, 479, 480, 511};
        foreach (edge_hues[i])
            send_hsv(HUE_W'(edge_hues[i]), 8'd255, (i < 13) ? 8'd255 : 8'd200);
        send_hsv(9'd200, 8'd0, 8'd137);
        send_hsv(9'd511, 8'd0, 8'd255);
        send_hsv(9'd90, 8'd255, 8'd0);
        send_hsv(9'd30, 8'd1, 8'd255);
        send_hsv(9'd256, 8'd128, 8'd1);
        send_hsv(9'd150, 8'd254, 8'd128);
    endtask

    // random colors with idling on both sides
    task automatic test_random_colors(input int n);
        no_gaps = 1'b0;
        send_random_colors(n);
    endtask

    // full rate on both sides, no idling at all
    task automatic test_back_to_back(input int n);
        no_gaps = 1'b1;
        send_random_colors(n);
        no_gaps = 1'b0;
    endtask

    // hold requests off until every pending result has come back, then send 20 random colors
    task automatic test_pause_for_results();
        hsv_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        send_random_colors(20);
    endtask

    // result checker and random output stall
    always @(posedge clk)
    begin
        rgb_color_t want;
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (pending_colors.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                want = pending_colors.pop_front();
                if (red !== want.red)
                    report_mismatch($sformatf("red %0d, want %0d", red, want.red));
                if (green !== want.green)
                    report_mismatch($sformatf("green %0d, want %0d", green, want.green));
                if (blue !== want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", blue, want.blue));
                if (packed_color !== want.packed_color)
                    report_mismatch($sformatf("packed_color %06h, want %06h",
                                              packed_color, want.packed_color));
            end
        end
        rgb_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((hsv_valid && !hsv_stall) || (rgb_valid && !rgb_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_colors();
        test_random_colors(500);
        test_back_to_back(350);
        test_pause_for_results();
        test_random_colors(580);
        hsv_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
